// File: hw/rtl/plfsr_pkg.sv
// shared types, constants and helpers for the programmable lfsr byte stream
package plfsr_pkg;

    localparam int NUM_CELLS = 8;
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = NUM_CELLS * BYTE_W;
    localparam int LEN_W     = 4;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TAP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd2;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [NUM_CELLS-1:0][BYTE_W-1:0] byte_vec_t;

    // per-cycle control shared by every cell
    typedef struct packed {
        logic advance;
        logic load;
    } cell_ctrl_t;

    // which cells hold live bytes and which one takes the feedback byte
    typedef struct packed {
        logic [NUM_CELLS-1:0] en;
        logic [NUM_CELLS-1:0] last;
    } cell_sel_t;

    // clamp the byte length to 1..NUM_CELLS and decode it into cell selects
    function automatic cell_sel_t length_to_sel(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] n;
        cell_sel_t        sel;
        n = len;
        if (n == '0)
        begin
            n = LEN_W'(1);
        end
        if (n > LEN_W'(NUM_CELLS))
        begin
            n = LEN_W'(NUM_CELLS);
        end
        for (int b = 0; b < NUM_CELLS; b++)
        begin
            sel.en[b]   = (LEN_W'(b) < n);
            sel.last[b] = (LEN_W'(b + 1) == n);
        end
        return sel;
    endfunction

endpackage

// File: hw/rtl/plfsr_cell.sv
// one byte cell of the lfsr window with its share of the eight parity sums
module plfsr_cell
    import plfsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       en,
    input  logic       last,
    input  byte_t      seed_byte,
    input  byte_t      tap_cur,
    input  byte_t      tap_prev,
    input  byte_t      nbr_byte,
    input  byte_t      fb_byte,
    output byte_t      cur_byte,
    output byte_t      partial
);

    byte_t data_reg;
    byte_t data_next;
    byte_t src;

    // live contents: seed on reload, zero when the cell lies past the length
    always_comb
    begin
        src      = ctrl.load ? seed_byte : data_reg;
        cur_byte = en ? src : '0;
    end

    // partial parity for each of the eight feedback bits of this step
    // bit j pairs sequence bit m with tap m-j, reaching into the lower tap byte
    always_comb
    begin
        logic acc;
        acc = 1'b0;
        for (int j = 0; j < BYTE_W; j++)
        begin
            acc = 1'b0;
            for (int i = 0; i < BYTE_W; i++)
            begin
                if (i >= j)
                begin
                    acc = acc ^ (tap_cur[BYTE_W-1-(i-j)] & cur_byte[BYTE_W-1-i]);
                end
                else
                begin
                    acc = acc ^ (tap_prev[j-i-1] & cur_byte[BYTE_W-1-i]);
                end
            end
            partial[BYTE_W-1-j] = acc;
        end
    end

    // shift one byte toward the output; the last live cell takes the new byte
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.advance)
        begin
            if (last)
            begin
                data_next = fb_byte;
            end
            else if (en)
            begin
                data_next = nbr_byte;
            end
            else
            begin
                data_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: hw/rtl/plfsr_fb.sv
// combines the cell parities into the eight new sequence bits of one step
module plfsr_fb
    import plfsr_pkg::*;
(
    input  byte_vec_t partials,
    input  byte_t     tail_tap,
    output byte_t     fb_byte
);

    always_comb
    begin
        byte_t p;
        byte_t f;
        logic  acc;
        p   = '0;
        f   = '0;
        acc = 1'b0;
        // xor tree across the cells
        for (int b = 0; b < NUM_CELLS; b++)
        begin
            p = p ^ partials[b];
        end
        // later bits also see the new bits already made in this step,
        // through the taps at the tail of the register
        for (int j = 0; j < BYTE_W; j++)
        begin
            acc = p[BYTE_W-1-j];
            for (int i = 0; i < BYTE_W; i++)
            begin
                if (i < j)
                begin
                    acc = acc ^ (tail_tap[j-i-1] & f[BYTE_W-1-i]);
                end
            end
            f[BYTE_W-1-j] = acc;
        end
        fb_byte = f;
    end

endmodule

// File: hw/rtl/programmable_lfsr_byte_stream.sv
// Programmable Fibonacci LFSR byte stream: each accepted request emits the
// oldest byte of an 8..64-bit window (MSB = earliest bit) and advances the
// window by eight feedback bits. A request with restart set reloads the window
// from the seed register first, so the first bytes after a restart are the seed bytes.
// One request per clock unless the output stalls: the window is a row of eight byte
// cells that shift by one cell per request, and the eight feedback bits come from
// parallel parity sums combinationally. Results appear in the cycle after acceptance
// in an output register; a request is taken while that register is empty or drains.
// Config (0 taps, 1 seed, 2 length in bytes) is to be written by the user while idle;
// the block does not enforce this, and cfg_ready is always high.
module programmable_lfsr_byte_stream
    import plfsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic                 restart,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [BYTE_W-1:0]    stream_byte,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    logic [WORD_W-1:0] tap_reg;
    logic [WORD_W-1:0] seed_reg;
    cell_sel_t         sel_reg;
    logic              result_valid_reg;
    logic              result_valid_next;
    byte_t             stream_byte_reg;

    logic       accept;
    cell_ctrl_t ctrl;
    byte_vec_t  cur_bytes;
    byte_vec_t  partials;
    byte_t      fb_byte;
    byte_t      tail_tap;

    // handshake
    assign cfg_ready         = 1'b1;
    assign item_stall        = result_valid_reg & result_stall;
    assign accept            = item_valid & ~item_stall;
    assign result_valid_next = accept | (result_valid_reg & result_stall);
    assign ctrl.advance      = accept;
    assign ctrl.load         = accept & restart;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg  <= '0;
            seed_reg <= '0;
            sel_reg  <= length_to_sel(LEN_W'(NUM_CELLS));
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TAP:    tap_reg  <= cfg_data;
                REG_SEED:   seed_reg <= cfg_data;
                REG_LENGTH: sel_reg  <= length_to_sel(cfg_data[LEN_W-1:0]);
                default:    ;
            endcase
        end
    end

    // tap byte of the last live cell, used for the in-step feedback terms
    always_comb
    begin
        tail_tap = '0;
        for (int b = 0; b < NUM_CELLS; b++)
        begin
            if (sel_reg.last[b])
            begin
                tail_tap = tail_tap | tap_reg[WORD_W-1-BYTE_W*b -: BYTE_W];
            end
        end
    end

    // row of byte cells, cell 0 holds the oldest byte
    for (genvar b = 0; b < NUM_CELLS; b++)
    begin : g_cell
        byte_t nbr_byte;
        byte_t tap_prev;

        if (b == NUM_CELLS - 1)
        begin : g_top
            assign nbr_byte = '0;
        end
        else
        begin : g_mid
            assign nbr_byte = cur_bytes[b+1];
        end

        if (b == 0)
        begin : g_first
            assign tap_prev = '0;
        end
        else
        begin : g_rest
            assign tap_prev = tap_reg[WORD_W-1-BYTE_W*(b-1) -: BYTE_W];
        end

        plfsr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .en        (sel_reg.en[b]),
            .last      (sel_reg.last[b]),
            .seed_byte (seed_reg[WORD_W-1-BYTE_W*b -: BYTE_W]),
            .tap_cur   (tap_reg[WORD_W-1-BYTE_W*b -: BYTE_W]),
            .tap_prev  (tap_prev),
            .nbr_byte  (nbr_byte),
            .fb_byte   (fb_byte),
            .cur_byte  (cur_bytes[b]),
            .partial   (partials[b])
        );
    end

    // feedback combine
    plfsr_fb u_fb (
        .partials (partials),
        .tail_tap (tail_tap),
        .fb_byte  (fb_byte)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stream_byte_reg <= cur_bytes[0];
        end
    end

    assign result_valid = result_valid_reg;
    assign stream_byte  = stream_byte_reg;

endmodule

// File: hw/rtl/plfsr_checker.sv
// port-level checks for the programmable lfsr byte stream
module plfsr_checker
    import plfsr_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_valid,
    input logic                 item_stall,
    input logic                 result_valid,
    input logic                 result_stall,
    input logic [BYTE_W-1:0]    stream_byte
);

    // a stalled result holds its value
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(stream_byte))
        else $error("stalled result changed");

    // every accepted request yields a result in the next cycle
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> result_valid)
        else $error("accepted request gave no result");

    // the input side only stalls behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("input stalled with empty output");

    // a taken result with no new request leaves the output empty
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !(item_valid && !item_stall) |=> !result_valid)
        else $error("result appeared without a request");

endmodule

bind programmable_lfsr_byte_stream plfsr_checker u_plfsr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stream_byte  (stream_byte)
);
